FILE: rtl/core/wrf_pkg.sv
package wrf_pkg;

    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 10;
    localparam int LW_W    = 11;
    localparam int MODE_W  = 2;
    localparam int GEO_W   = 13;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_RANK_MODE    = 2'd0;
    localparam logic [1:0] REG_LINE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0] RANK_MODE_RST    = 2'd1;
    localparam logic [LW_W-1:0]   LINE_WIDTH_RST   = 11'd1024;
    localparam logic [ROW_W-1:0]  FRAME_HEIGHT_RST = 12'd480;

    typedef enum logic [MODE_W-1:0] {
        MODE_MIN    = 2'd0,
        MODE_MEDIAN = 2'd1,
        MODE_MAX    = 2'd2
    } t_mode;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_tag;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_lb_ctl;

    typedef struct packed {
        logic adv;
        logic shift;
        logic emit;
    } t_win_ctl;

endpackage

FILE: rtl/core/wrf_line_buf.sv
module wrf_line_buf #(
    parameter int KSIZE     = 3,
    parameter int MAX_WIDTH = 1024,
    localparam int AW       = $clog2(MAX_WIDTH)
) (
    input  logic                            i_clk,
    input  wrf_pkg::t_lb_ctl                i_ctl,
    input  logic [AW-1:0]                   i_rd_addr,
    input  logic [AW-1:0]                   i_wr_addr,
    input  logic [wrf_pkg::PIX_W-1:0]       i_wr_pix,
    output logic [KSIZE*wrf_pkg::PIX_W-1:0] o_col
);
    import wrf_pkg::*;

    localparam int LW = (KSIZE - 1) * PIX_W;

    logic [LW-1:0] mem [MAX_WIDTH];
    logic [LW-1:0] r_rd;
    logic [LW-1:0] wdata;

    // Each entry holds one column of the stored lines, oldest line in the low byte.
    assign wdata = {i_wr_pix, r_rd[LW-1:PIX_W]};
    assign o_col = {i_wr_pix, r_rd};

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= wdata;
        end
        if (i_ctl.rd_en) begin
            if (i_ctl.wr_en && (i_rd_addr == i_wr_addr)) begin
                r_rd <= wdata;
            end else begin
                r_rd <= mem[i_rd_addr];
            end
        end
    end

endmodule

FILE: rtl/core/wrf_rank.sv
module wrf_rank #(
    parameter int KSIZE = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wrf_pkg::t_win_ctl               i_ctl,
    input  logic [KSIZE*wrf_pkg::PIX_W-1:0] i_col,
    input  wrf_pkg::t_tag                   i_tag,
    input  logic [wrf_pkg::MODE_W-1:0]      i_mode,
    output logic                            o_valid,
    output logic [wrf_pkg::PIX_W-1:0]       o_pix,
    output wrf_pkg::t_tag                   o_tag
);
    import wrf_pkg::*;

    localparam int N  = KSIZE * KSIZE;
    localparam int RW = $clog2(N);

    logic [PIX_W-1:0] r_win [N];
    logic             r_s2_valid;
    t_tag             r_s2_tag;

    logic             r_s3_valid;
    t_tag             r_s3_tag;
    logic [PIX_W-1:0] r_s3_vals [N];
    logic [N-1:0]     r_s3_lt [N];
    logic [N-1:0]     n_lt [N];

    logic             r_s4_valid;
    t_tag             r_s4_tag;
    logic [PIX_W-1:0] r_s4_vals [N];
    logic [N-1:0]     r_sel;
    logic [N-1:0]     n_sel;
    logic [RW-1:0]    target;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    t_tag             r_out_tag;
    logic [PIX_W-1:0] n_pix;

    function automatic logic [RW-1:0] count_ones(input logic [N-1:0] bits);
        logic [RW-1:0] sum;
        sum = '0;
        for (int i = 0; i < N; i++) begin
            sum = sum + RW'(bits[i]);
        end
        return sum;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_ctl.shift) begin
            for (int r = 0; r < KSIZE; r++) begin
                for (int c = 0; c < KSIZE - 1; c++) begin
                    r_win[r*KSIZE+c] <= r_win[r*KSIZE+c+1];
                end
                r_win[r*KSIZE+KSIZE-1] <= i_col[r*PIX_W +: PIX_W];
            end
        end
    end

    // Ties are broken by window position, so the ranks always form a permutation.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                n_lt[i][j] = (j != i) && ((r_win[j] < r_win[i]) ||
                             ((r_win[j] == r_win[i]) && (j < i)));
            end
        end
    end

    always_comb begin
        unique case (i_mode)
            MODE_MIN:    target = '0;
            MODE_MEDIAN: target = RW'(N / 2);
            default:     target = RW'(N - 1);
        endcase
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_sel[i] = (count_ones(r_s3_lt[i]) == target);
        end
    end

    always_comb begin
        n_pix = '0;
        for (int i = 0; i < N; i++) begin
            n_pix = n_pix | (r_sel[i] ? r_s4_vals[i] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_s2_valid  <= i_ctl.shift && i_ctl.emit;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s2_tag  <= i_tag;
            r_s3_tag  <= r_s2_tag;
            r_s3_vals <= r_win;
            r_s3_lt   <= n_lt;
            r_s4_tag  <= r_s3_tag;
            r_s4_vals <= r_s3_vals;
            r_sel     <= n_sel;
            r_out_tag <= r_s4_tag;
            r_out_pix <= n_pix;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out_pix;
    assign o_tag   = r_out_tag;

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> $onehot(r_sel))
        else $error("rank select is not one-hot");

endmodule

FILE: rtl/core/window_rank_filter_top.sv
// Rank filter over a grey pixel stream: minimum, median or maximum of a square window.
// Pixels enter in raster order on the input channel (i_in_valid, o_in_stall), one per
// request, with i_frame_start marking the first pixel of a frame. A result request on
// the output channel (o_out_valid, i_out_stall) carries the ranked value and the row and
// column of the window centre; o_frame_last marks the last result of a frame. Border
// pixels produce no result.
// The block takes one pixel per cycle while the output is not stalled. Each result passes
// in order through the line memory read, the window, the comparison stage, the rank count
// stage and the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and the input
// channel stalls in the same cycle; it resumes as soon as the result is taken.
// Reset clears the counters, the window and the pipeline and loads the register defaults
// (median, 1024 pixels per line, 480 lines). The line memory is not cleared; the first
// rows of a frame fill it before any of it is used.
// Registers are written through the APB port: rank mode at 0x0, line width at 0x4 and
// frame height at 0x8. Users must write only while the block is idle; it is not enforced.
module window_rank_filter_top #(
    parameter int KSIZE     = 3,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wrf_pkg::PADDR_W-1:0]   paddr,
    input  logic [wrf_pkg::PDATA_W-1:0]   pwdata,
    output logic [wrf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [wrf_pkg::PIX_W-1:0]     i_pixel_in,
    input  logic                          i_frame_start,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [wrf_pkg::PIX_W-1:0]     o_pixel_out,
    output logic [wrf_pkg::ROW_W-1:0]     o_out_row,
    output logic [wrf_pkg::COL_W-1:0]     o_out_col,
    output logic                          o_frame_last
);
    import wrf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int HALFK = KSIZE / 2;

    logic [MODE_W-1:0] r_rank_mode;
    logic [LW_W-1:0]   r_line_width;
    logic [ROW_W-1:0]  r_frame_height;

    logic [GEO_W-1:0]  w_eff;
    logic [GEO_W-1:0]  h_eff;
    logic [GEO_W-1:0]  lw_ext;
    logic [GEO_W-1:0]  fh_ext;

    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CW-1:0]     n_col;
    logic [ROW_W-1:0]  n_row;
    logic [CW-1:0]     col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic [GEO_W-1:0]  col_ext;
    logic [GEO_W-1:0]  row_ext;
    logic [GEO_W-1:0]  col_inc;
    logic [GEO_W-1:0]  row_inc;
    logic [GEO_W-1:0]  col_ctr;
    logic              emit;
    t_tag              tag;

    logic              en;
    logic              accept;

    logic              r_s1_valid;
    logic [CW-1:0]     r_s1_addr;
    logic [PIX_W-1:0]  r_s1_pix;
    logic              r_s1_emit;
    t_tag              r_s1_tag;

    t_lb_ctl           lb_ctl;
    t_win_ctl          win_ctl;
    logic [KSIZE*PIX_W-1:0] col_data;
    t_tag              out_tag;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank_mode    <= RANK_MODE_RST;
            r_line_width   <= LINE_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_RANK_MODE:    r_rank_mode    <= pwdata[MODE_W-1:0];
                REG_LINE_WIDTH:   r_line_width   <= pwdata[LW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_RANK_MODE:    prdata = PDATA_W'(r_rank_mode);
            REG_LINE_WIDTH:   prdata = PDATA_W'(r_line_width);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // Effective geometry.
    assign lw_ext = GEO_W'(r_line_width);
    assign fh_ext = GEO_W'(r_frame_height);

    always_comb begin
        if (lw_ext < GEO_W'(KSIZE)) begin
            w_eff = GEO_W'(KSIZE);
        end else if (lw_ext > GEO_W'(MAX_WIDTH)) begin
            w_eff = GEO_W'(MAX_WIDTH);
        end else begin
            w_eff = lw_ext;
        end
        if (fh_ext < GEO_W'(KSIZE)) begin
            h_eff = GEO_W'(KSIZE);
        end else begin
            h_eff = fh_ext;
        end
    end

    // Raster position of the incoming pixel.
    assign en     = !o_out_valid || !i_out_stall;
    assign accept = i_in_valid && en;
    assign o_in_stall = !en;

    assign col_cur = i_frame_start ? '0 : r_col;
    assign row_cur = i_frame_start ? '0 : r_row;
    assign col_ext = GEO_W'(col_cur);
    assign row_ext = GEO_W'(row_cur);
    assign col_inc = col_ext + GEO_W'(1);
    assign row_inc = row_ext + GEO_W'(1);
    assign col_ctr = col_ext - GEO_W'(HALFK);

    assign emit = (row_ext >= GEO_W'(KSIZE - 1)) && (col_ext >= GEO_W'(KSIZE - 1)) &&
                  (col_ext < w_eff) && (row_ext < h_eff);

    always_comb begin
        tag.row  = row_cur - ROW_W'(HALFK);
        tag.col  = col_ctr[COL_W-1:0];
        tag.last = (row_ext == h_eff - GEO_W'(1)) && (col_ext == w_eff - GEO_W'(1));
    end

    always_comb begin
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = (row_ext >= h_eff) ? '0 : row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (en) begin
                r_s1_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr <= col_cur;
            r_s1_pix  <= i_pixel_in;
            r_s1_emit <= emit;
            r_s1_tag  <= tag;
        end
    end

    assign lb_ctl.rd_en = accept;
    assign lb_ctl.wr_en = en && r_s1_valid;

    wrf_line_buf #(
        .KSIZE     (KSIZE),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_ctl     (lb_ctl),
        .i_rd_addr (col_cur),
        .i_wr_addr (r_s1_addr),
        .i_wr_pix  (r_s1_pix),
        .o_col     (col_data)
    );

    assign win_ctl.adv   = en;
    assign win_ctl.shift = en && r_s1_valid;
    assign win_ctl.emit  = r_s1_emit;

    wrf_rank #(
        .KSIZE (KSIZE)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (win_ctl),
        .i_col   (col_data),
        .i_tag   (r_s1_tag),
        .i_mode  (r_rank_mode),
        .o_valid (o_out_valid),
        .o_pix   (o_pixel_out),
        .o_tag   (out_tag)
    );

    assign o_out_row    = out_tag.row;
    assign o_out_col    = out_tag.col;
    assign o_frame_last = out_tag.last;

    a_col_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (GEO_W'(r_col) < w_eff))
        else $error("column counter beyond line width after a pixel");

    a_last_at_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_last) |->
            ((GEO_W'(o_out_row) == h_eff - GEO_W'(1 + HALFK)) &&
             (o_out_col == COL_W'(w_eff - GEO_W'(1 + HALFK)))))
        else $error("frame end flagged away from the last interior pixel");

    a_stall_holds_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !en) |=> (r_s1_valid && $stable(r_s1_addr)))
        else $error("line memory write lost while the output is stalled");

endmodule
